// ===== design/sptok_pkg.sv =====
// shared constants and types for the script push element tokenizer
package sptok_pkg;

   localparam int MAX_SCRIPT_BYTES = 65535;
   localparam int ByteCntW         = $clog2(MAX_SCRIPT_BYTES + 1);

   localparam int IdxW      = 16;
   localparam int ElemCntW  = IdxW + 1;
   localparam int ReqDataW  = 8;
   localparam int RspDataW  = 40;

   typedef struct packed {
      logic            element_start;
      logic [IdxW-1:0] element_index;
      logic            done_res;
      logic [IdxW-1:0] element_count;
      logic            well_formed;
   } sptok_result_type;

endpackage

// ===== design/sptok_walk.sv =====
// element walk state and per-byte result logic
module sptok_walk import sptok_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       script_byte,
   input  logic             last_byte,
   output sptok_result_type result
);

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_LENGTH,
      PH_DATA
   } phase_type;

   localparam logic [7:0] OpcPushdata1 = 8'd76;
   localparam logic [7:0] OpcPushdata2 = 8'd77;
   localparam logic [7:0] OpcPushdata4 = 8'd78;
   localparam logic [ElemCntW-1:0] ElemLimit = ElemCntW'(1 << IdxW);
   localparam logic [ByteCntW-1:0] ByteMax   = ByteCntW'(MAX_SCRIPT_BYTES);

   phase_type            phase_ff, phase_in;
   logic [2:0]           len_left_ff, len_left_in;
   logic [1:0]           len_shift_ff, len_shift_in;
   logic [31:0]          push_len_ff, push_len_in;
   logic [31:0]          data_left_ff, data_left_in;
   logic [ElemCntW-1:0]  elems_ff, elems_in;
   logic [ByteCntW-1:0]  bytes_ff, bytes_in;
   logic                 overflow_ff, overflow_in;

   logic                 start;
   logic [31:0]          merged;
   logic [2:0]           len_dec;
   logic [31:0]          data_dec;
   logic [ElemCntW-1:0]  idx_wide;
   logic                 wf;

   always_comb begin
      phase_in     = phase_ff;
      len_left_in  = len_left_ff;
      len_shift_in = len_shift_ff;
      push_len_in  = push_len_ff;
      data_left_in = data_left_ff;
      elems_in     = elems_ff;
      bytes_in     = bytes_ff;
      overflow_in  = overflow_ff;
      start        = 1'b0;
      merged       = push_len_ff | ({24'd0, script_byte} << {len_shift_ff, 3'b000});
      len_dec      = len_left_ff - {2'd0, (len_left_ff != 3'd0)};
      data_dec     = data_left_ff - {31'd0, (data_left_ff != 32'd0)};

      // this transfer is byte number MAX+1 or later
      if (bytes_ff == ByteMax) begin
         overflow_in = 1'b1;
      end else begin
         bytes_in = bytes_ff + 1'b1;
      end

      unique case (phase_ff)
         PH_LENGTH: begin
            push_len_in  = merged;
            len_shift_in = len_shift_ff + 2'd1;
            len_left_in  = len_dec;
            if (len_dec == 3'd0) begin
               if (merged == 32'd0) begin
                  phase_in = PH_OPCODE;
               end else begin
                  phase_in     = PH_DATA;
                  data_left_in = merged;
               end
            end
         end
         PH_DATA: begin
            data_left_in = data_dec;
            if (data_dec == 32'd0) begin
               phase_in = PH_OPCODE;
            end
         end
         default: begin
            start    = 1'b1;
            elems_in = elems_ff + {{(ElemCntW-1){1'b0}}, (elems_ff != ElemLimit)};
            if (script_byte == OpcPushdata1 || script_byte == OpcPushdata2 ||
                script_byte == OpcPushdata4) begin
               phase_in     = PH_LENGTH;
               len_left_in  = (script_byte == OpcPushdata1) ? 3'd1 :
                              (script_byte == OpcPushdata2) ? 3'd2 : 3'd4;
               len_shift_in = 2'd0;
               push_len_in  = 32'd0;
            end else if (script_byte != 8'd0 && script_byte < OpcPushdata1) begin
               phase_in     = PH_DATA;
               data_left_in = {24'd0, script_byte};
            end else begin
               phase_in = PH_OPCODE;
            end
         end
      endcase

      idx_wide = (elems_in == '0) ? '0 : elems_in - 1'b1;
      wf       = (phase_in == PH_OPCODE) && !overflow_in && !elems_in[ElemCntW-1];

      result.element_start = start;
      result.element_index = idx_wide[IdxW-1:0];
      result.done_res      = last_byte;
      result.element_count = (last_byte && wf) ? elems_in[IdxW-1:0] : '0;
      result.well_formed   = last_byte && wf;
   end

   always_ff @(posedge clock) begin
      // the final byte returns the walk to its reset state
      if (reset || (take && last_byte)) begin
         phase_ff     <= PH_OPCODE;
         len_left_ff  <= '0;
         len_shift_ff <= '0;
         push_len_ff  <= '0;
         data_left_ff <= '0;
         elems_ff     <= '0;
         bytes_ff     <= '0;
         overflow_ff  <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         len_left_ff  <= len_left_in;
         len_shift_ff <= len_shift_in;
         push_len_ff  <= push_len_in;
         data_left_ff <= data_left_in;
         elems_ff     <= elems_in;
         bytes_ff     <= bytes_in;
         overflow_ff  <= overflow_in;
      end
   end

endmodule

// ===== design/script_push_element_tokenizer.sv =====
// top level: script element tokenizer with input and result registers
//
//  channel  direction  tdata                                   tuser          tlast
//  req_     in         [7:0] script_byte                       -              last_byte
//  rsp_     out        [15:0] element_index,                   element_start  done_res
//                      [31:16] element_count, [32] well_formed
//
// one byte per clock sustained while rsp_ is not stalled; each byte passes from req to rsp through
// the input register, then the walk update into the result register
// the walk state advances only when the input register hands its byte on
// reset clears the walk and both valid flags; no clearing pass is needed
// a stalled rsp_ holds its result, and req_ keeps flowing until the input register fills
module script_push_element_tokenizer import sptok_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // [7:0] script_byte
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [15:0] element_index, [31:16] element_count,
                                            // [32] well_formed, [39:33] zero
   output logic                rsp_tuser,   // [0] element_start
   output logic                rsp_tlast
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sptok_result_type res_ff;
   sptok_result_type res_comb;
   logic             advance;
   logic             req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   sptok_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .take        (advance),
      .script_byte (in_byte_ff),
      .last_byte   (in_last_ff),
      .result      (res_comb)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.well_formed, res_ff.element_count, res_ff.element_index};
   assign rsp_tuser  = res_ff.element_start;
   assign rsp_tlast  = res_ff.done_res;

endmodule

// ===== bench/sptok_bench_pkg.sv =====
// opcode constants shared by the tokenizer testbench files
`timescale 1ns / 100ps

package sptok_bench_pkg;

   localparam logic [7:0] OP_ZERO       = 8'h00;
   localparam logic [7:0] OP_PUSH_LEN8  = 8'h4c;
   localparam logic [7:0] OP_PUSH_LEN16 = 8'h4d;
   localparam logic [7:0] OP_PUSH_LEN32 = 8'h4e;

endpackage

// ===== bench/sptok_stream_checker.sv =====
// stream checker: predicts the element walk of each script and compares every result
`timescale 1ns / 100ps

module sptok_stream_checker import sptok_pkg::*, sptok_bench_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                rsp_tlast,
   output int                  fail_count,
   output int                  pending,
   output int                  results_checked,
   output int                  scripts_seen,
   output int                  scripts_intact
);

   typedef enum logic [1:0] {WALK_OPCODE, WALK_LENGTH, WALK_DATA} walk_mode_type;

   localparam logic [ElemCntW-1:0] ELEM_SAT = ElemCntW'(1 << IdxW);

   walk_mode_type         walk_mode;
   logic [2:0]            len_bytes_due;
   logic [1:0]            len_pos;
   logic [31:0]           len_accum;
   logic [31:0]           payload_due;
   logic [ElemCntW-1:0]   elem_total;
   logic [ByteCntW:0]     byte_total;
   logic                  too_long;

   sptok_result_type      element_results[$];
   sptok_result_type      want;

   function automatic void clear_walk();
      walk_mode     = WALK_OPCODE;
      len_bytes_due = '0;
      len_pos       = '0;
      len_accum     = '0;
      payload_due   = '0;
      elem_total    = '0;
      byte_total    = '0;
      too_long      = 1'b0;
   endfunction

   // advance the walk by one script byte and return what the block should report
   function automatic sptok_result_type walk_byte(input logic [7:0] b, input logic fin);
      sptok_result_type r;
      logic             intact;
      r = '0;
      if (byte_total <= MAX_SCRIPT_BYTES)
         byte_total++;
      if (byte_total > MAX_SCRIPT_BYTES)
         too_long = 1'b1;

      case (walk_mode)
         WALK_LENGTH: begin
            len_accum = len_accum | (32'(b) << (8 * len_pos));
            len_pos++;
            if (len_bytes_due != 0)
               len_bytes_due--;
            if (len_bytes_due == 0) begin
               if (len_accum == 0) begin
                  walk_mode = WALK_OPCODE;
               end else begin
                  walk_mode   = WALK_DATA;
                  payload_due = len_accum;
               end
            end
         end
         WALK_DATA: begin
            if (payload_due != 0)
               payload_due--;
            if (payload_due == 0)
               walk_mode = WALK_OPCODE;
         end
         default: begin
            r.element_start = 1'b1;
            if (elem_total < ELEM_SAT)
               elem_total++;
            if (b == OP_PUSH_LEN8 || b == OP_PUSH_LEN16 || b == OP_PUSH_LEN32) begin
               walk_mode     = WALK_LENGTH;
               len_bytes_due = (b == OP_PUSH_LEN8) ? 3'd1 : (b == OP_PUSH_LEN16) ? 3'd2 : 3'd4;
               len_pos       = '0;
               len_accum     = '0;
            end else if (b != OP_ZERO && b < OP_PUSH_LEN8) begin
               walk_mode   = WALK_DATA;
               payload_due = 32'(b);
            end else begin
               walk_mode = WALK_OPCODE;
            end
         end
      endcase

      // elem_total never passes 65536, so the index fits without clamping
      r.element_index = (elem_total == 0) ? '0 : IdxW'(elem_total - 1'b1);
      r.done_res      = fin;
      if (fin) begin
         intact          = (walk_mode == WALK_OPCODE) && !too_long && (elem_total < ELEM_SAT);
         r.well_formed   = intact;
         r.element_count = intact ? elem_total[IdxW-1:0] : '0;
         clear_walk();
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         element_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (element_results.size() == 0) begin
               fail_count++;
               $display("%0t: result transfer with nothing expected, actual tdata %0h",
                        $time, rsp_tdata);
            end else begin
               want = element_results.pop_front();
               check_field("element_start", 32'(want.element_start), 32'(rsp_tuser));
               check_field("element_index", 32'(want.element_index), 32'(rsp_tdata[15:0]));
               check_field("done_res", 32'(want.done_res), 32'(rsp_tlast));
               check_field("element_count", 32'(want.element_count), 32'(rsp_tdata[31:16]));
               check_field("well_formed", 32'(want.well_formed), 32'(rsp_tdata[32]));
               check_field("tdata padding", 32'h0, 32'(rsp_tdata[RspDataW-1:33]));
               results_checked++;
               if (want.done_res) begin
                  scripts_seen++;
                  if (want.well_formed)
                     scripts_intact++;
               end
            end
         end
         if (req_tvalid && req_tready)
            element_results.push_back(walk_byte(req_tdata, req_tlast));
      end
      pending <= element_results.size();
   end

endmodule

// ===== bench/tb_script_push_element_tokenizer.sv =====
// testbench top: drives script bytes into the tokenizer and gives the verdict
`timescale 1ns / 100ps

module tb_script_push_element_tokenizer;
   import sptok_pkg::*;
   import sptok_bench_pkg::*;

   localparam int RANDOM_BYTES = 1550;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   int fail_count;
   int pending;
   int results_checked;
   int scripts_seen;
   int scripts_intact;

   int cycles;
   int send_idle_pct;
   int stall_pct;
   int bytes_sent;
   int random_bytes;

   logic [7:0] script_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   script_push_element_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sptok_stream_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .scripts_seen    (scripts_seen),
      .scripts_intact  (scripts_intact)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // valid stays high between back-to-back transfers, it only drops for a gap
   task automatic push_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_script();
      foreach (script_bytes[i]) begin
         push_byte(script_bytes[i], i == script_bytes.size() - 1);
         bytes_sent++;
      end
   endtask

   task automatic add_payload(input int len);
      repeat (len)
         script_bytes.push_back(8'($urandom));
   endtask

   task automatic add_element();
      int         sel;
      int         len;
      int         len_size;
      logic [7:0] op;
      sel = $urandom_range(9);
      if (sel < 2) begin
         script_bytes.push_back(($urandom_range(3) == 0) ? OP_ZERO
                                : 8'($urandom_range(255, OP_PUSH_LEN32 + 1)));
      end else if (sel < 5) begin
         // direct push, mostly short, now and then up to the largest
         len = ($urandom_range(7) == 0) ? $urandom_range(OP_PUSH_LEN8 - 1, 1)
                                        : $urandom_range(8, 1);
         script_bytes.push_back(8'(len));
         add_payload(len);
      end else begin
         op       = (sel < 7) ? OP_PUSH_LEN8 : (sel < 9) ? OP_PUSH_LEN16 : OP_PUSH_LEN32;
         len_size = (op == OP_PUSH_LEN8) ? 1 : (op == OP_PUSH_LEN16) ? 2 : 4;
         len      = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
         script_bytes.push_back(op);
         for (int k = 0; k < len_size; k++)
            script_bytes.push_back(8'(len >> (8 * k)));
         add_payload(len);
      end
   endtask

   // mostly well formed walks; some cut short, some raw noise
   task automatic random_script();
      int kind;
      int cut;
      script_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 80) begin
         repeat ($urandom_range(6, 1))
            add_element();
         if (kind >= 65 && script_bytes.size() > 1) begin
            cut = $urandom_range(script_bytes.size() - 1, 1);
            while (script_bytes.size() > cut)
               void'(script_bytes.pop_back());
         end
      end else begin
         repeat ($urandom_range(30, 1))
            script_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic directed_scripts();
      script_bytes = '{OP_ZERO};
      send_script();
      script_bytes = '{8'hff};
      send_script();
      // zero length on all three length-prefixed pushes
      script_bytes = '{OP_PUSH_LEN8, 8'h00, OP_PUSH_LEN16, 8'h00, 8'h00,
                       OP_PUSH_LEN32, 8'h00, 8'h00, 8'h00, 8'h00};
      send_script();
      script_bytes = '{8'h01, 8'h5a};
      send_script();
      script_bytes = '{OP_PUSH_LEN8, 8'h02, 8'h11, 8'h22, 8'h4f};
      send_script();
      // truncated inside the payload, then inside the length
      script_bytes = '{OP_PUSH_LEN32, 8'hff, 8'hff, 8'hff, 8'hff};
      send_script();
      script_bytes = '{OP_PUSH_LEN16, 8'h01};
      send_script();
   endtask

   initial begin
      int idle_plan[4][2];
      idle_plan = '{'{0, 0}, '{51, 0}, '{0, 51}, '{27, 27}};
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p][0];
         stall_pct     = idle_plan[p][1];
         if (p == 0)
            directed_scripts();
         while (random_bytes < RANDOM_BYTES * (p + 1) / 4) begin
            random_script();
            send_script();
            random_bytes += script_bytes.size();
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d bytes in %0d scripts, %0d of them well formed",
               bytes_sent, scripts_seen, scripts_intact);
      $display("%0d results checked, with zero-length and truncated pushes among them",
               results_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
